// ===== hw/rtl/kw1281_block_transfer_assert.svh =====
// Assertion macros shared by the KW1281 block transfer RTL.
`ifndef KW1281_BLOCK_TRANSFER_ASSERT_SVH
`define KW1281_BLOCK_TRANSFER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define KW1281_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kw1281 assertion failed");
// Check that a condition never holds on a rising clk edge outside reset.
`define KW1281_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("kw1281 forbidden condition seen");
`else
`define KW1281_ASSERT(lbl, prop)
`define KW1281_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/kw1281_pkg.sv =====
// Types and constants shared by the KW1281 block transfer RTL.
package kw1281_pkg;

    localparam logic [2:0] FUNC_START_RX  = 3'd0;
    localparam logic [2:0] FUNC_RX_BYTE   = 3'd1;
    localparam logic [2:0] FUNC_TICK      = 3'd2;
    localparam logic [2:0] FUNC_TX_BYTE   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_CNT = 3'd4;

    localparam logic [7:0]  BYTE_MASK     = 8'hFF;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1100;

    // Register index, taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RX,
        MODE_WAIT_COMPL,
        MODE_TX
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_TOO_LONG,
        ERR_BAD_COUNTER,
        ERR_NO_RESPONSE,
        ERR_TIMEOUT,
        ERR_BAD_COMPL,
        ERR_SEQUENCE
    } err_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic [6:0] expected_size;
        logic [6:0] size_limit;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       rx_valid;
        logic [5:0] rx_index;
        logic       block_done;
        err_t       error_code;
        logic [7:0] counter_value;
    } result_t;

endpackage

// ===== hw/rtl/kw1281_engine.sv =====
// KW1281 protocol state and the single-pass decision logic for one transaction.
module kw1281_engine #(
    parameter int MAX_BLOCK = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  kw1281_pkg::item_t   item,
    input  logic [15:0]         timeout_ticks,
    output kw1281_pkg::result_t res
);

    kw1281_pkg::mode_t mode_reg, mode_next;
    logic [7:0]  block_count_reg, block_count_next;
    logic [6:0]  received_reg, received_next;
    logic [8:0]  target_reg, target_next;
    logic [6:0]  limit_reg, limit_next;
    logic        ack_reg, ack_next;
    logic [7:0]  sent_byte_reg, sent_byte_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [6:0]  lim_clamped;
    logic        start_ok;
    logic [8:0]  tgt_from_byte;
    logic [8:0]  tgt_eff;
    logic [7:0]  cnt;
    logic        rx_len_err;
    logic        rx_cnt_err;
    logic        rx_last;
    logic        rx_ack;
    logic        compl_ok;
    logic [15:0] ticks_inc;
    logic        tick_active;
    logic        tick_expired;
    logic        tx_allowed;

    // Shared decisions
    assign lim_clamped   = ({3'b000, item.size_limit} > 10'(MAX_BLOCK)) ? 7'(MAX_BLOCK)
                                                                        : item.size_limit;
    assign start_ok      = item.expected_size <= lim_clamped;
    assign tgt_from_byte = {1'b0, item.data} + 9'd1;
    assign tgt_eff       = (target_reg == 9'd0) ? tgt_from_byte : target_reg;
    assign cnt           = {1'b0, received_reg} + 8'd1;
    assign rx_len_err    = (target_reg == 9'd0) && (tgt_from_byte > {2'b00, limit_reg});
    assign rx_cnt_err    = !rx_len_err && ack_reg && (cnt == 8'd2)
                           && (item.data != block_count_reg);
    assign rx_last       = {1'b0, cnt} >= tgt_eff;
    assign rx_ack        = (!ack_reg && ({1'b0, cnt} == tgt_eff))
                           || (ack_reg && ({1'b0, cnt} < tgt_eff));
    assign compl_ok      = item.data == (sent_byte_reg ^ kw1281_pkg::BYTE_MASK);
    assign ticks_inc     = (ticks_reg != kw1281_pkg::TICKS_MAX) ? ticks_reg + 16'd1
                                                                : ticks_reg;
    assign tick_expired  = ticks_inc >= timeout_ticks;
    assign tick_active   = (mode_reg == kw1281_pkg::MODE_RX)
                           || (mode_reg == kw1281_pkg::MODE_WAIT_COMPL);
    assign tx_allowed    = (mode_reg == kw1281_pkg::MODE_IDLE)
                           || (mode_reg == kw1281_pkg::MODE_TX);

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (item.func)
            kw1281_pkg::FUNC_START_RX:
            begin
                mode_next = start_ok ? kw1281_pkg::MODE_RX : kw1281_pkg::MODE_IDLE;
            end
            kw1281_pkg::FUNC_RX_BYTE:
            begin
                if (mode_reg == kw1281_pkg::MODE_RX)
                begin
                    if (rx_len_err || rx_cnt_err || rx_last)
                        mode_next = kw1281_pkg::MODE_IDLE;
                end
                else if (mode_reg == kw1281_pkg::MODE_WAIT_COMPL)
                begin
                    mode_next = compl_ok ? kw1281_pkg::MODE_TX : kw1281_pkg::MODE_IDLE;
                end
            end
            kw1281_pkg::FUNC_TICK:
            begin
                if (tick_active && tick_expired)
                    mode_next = kw1281_pkg::MODE_IDLE;
            end
            kw1281_pkg::FUNC_TX_BYTE:
            begin
                if (tx_allowed)
                    mode_next = item.last_byte ? kw1281_pkg::MODE_IDLE
                                               : kw1281_pkg::MODE_WAIT_COMPL;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Result and the remaining state
    always_comb
    begin
        block_count_next = block_count_reg;
        received_next    = received_reg;
        target_next      = target_reg;
        limit_next       = limit_reg;
        ack_next         = ack_reg;
        sent_byte_next   = sent_byte_reg;
        ticks_next       = ticks_reg;
        res              = '0;
        res.error_code   = kw1281_pkg::ERR_NONE;

        unique case (item.func)
            kw1281_pkg::FUNC_START_RX:
            begin
                if (!start_ok)
                begin
                    res.error_code = kw1281_pkg::ERR_TOO_LONG;
                end
                else
                begin
                    target_next   = {2'b00, item.expected_size};
                    limit_next    = lim_clamped;
                    received_next = 7'd0;
                    ack_next      = item.expected_size == 7'd0;
                    ticks_next    = 16'd0;
                end
            end
            kw1281_pkg::FUNC_RX_BYTE:
            begin
                if (mode_reg == kw1281_pkg::MODE_RX)
                begin
                    // The length byte sets the target even when it is then rejected
                    if (target_reg == 9'd0)
                        target_next = tgt_from_byte;
                    if (rx_len_err)
                    begin
                        res.error_code = kw1281_pkg::ERR_TOO_LONG;
                    end
                    else if (rx_cnt_err)
                    begin
                        res.error_code = kw1281_pkg::ERR_BAD_COUNTER;
                    end
                    else
                    begin
                        received_next = cnt[6:0];
                        res.rx_valid  = 1'b1;
                        res.rx_index  = received_reg[5:0];
                        if (rx_ack)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_data  = item.data ^ kw1281_pkg::BYTE_MASK;
                        end
                        ticks_next = 16'd0;
                        if (rx_last)
                        begin
                            block_count_next = block_count_reg + 8'd1;
                            res.block_done   = 1'b1;
                        end
                    end
                end
                else if (mode_reg == kw1281_pkg::MODE_WAIT_COMPL)
                begin
                    if (compl_ok)
                        ticks_next = 16'd0;
                    else
                        res.error_code = kw1281_pkg::ERR_BAD_COMPL;
                end
                else
                begin
                    res.error_code = kw1281_pkg::ERR_SEQUENCE;
                end
            end
            kw1281_pkg::FUNC_TICK:
            begin
                if (tick_active)
                begin
                    ticks_next = ticks_inc;
                    if (tick_expired)
                    begin
                        if ((mode_reg == kw1281_pkg::MODE_RX) && (received_reg == 7'd0))
                            res.error_code = kw1281_pkg::ERR_NO_RESPONSE;
                        else
                            res.error_code = kw1281_pkg::ERR_TIMEOUT;
                    end
                end
            end
            kw1281_pkg::FUNC_TX_BYTE:
            begin
                if (tx_allowed)
                begin
                    res.tx_valid = 1'b1;
                    res.tx_data  = item.data;
                    if (item.last_byte)
                    begin
                        block_count_next = block_count_reg + 8'd1;
                        res.block_done   = 1'b1;
                    end
                    else
                    begin
                        sent_byte_next = item.data;
                        ticks_next     = 16'd0;
                    end
                end
                else
                begin
                    res.error_code = kw1281_pkg::ERR_SEQUENCE;
                end
            end
            kw1281_pkg::FUNC_CLEAR_CNT:
            begin
                block_count_next = 8'd0;
            end
            default:
            begin
                block_count_next = block_count_reg;
            end
        endcase

        res.counter_value = block_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= kw1281_pkg::MODE_IDLE;
            block_count_reg <= 8'd0;
            received_reg    <= 7'd0;
            target_reg      <= 9'd0;
            limit_reg       <= 7'd0;
            ack_reg         <= 1'b0;
            sent_byte_reg   <= 8'd0;
            ticks_reg       <= 16'd0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            block_count_reg <= block_count_next;
            received_reg    <= received_next;
            target_reg      <= target_next;
            limit_reg       <= limit_next;
            ack_reg         <= ack_next;
            sent_byte_reg   <= sent_byte_next;
            ticks_reg       <= ticks_next;
        end
    end

`include "kw1281_block_transfer_assert.svh"

    `KW1281_ASSERT(a_done_to_idle,
        step && res.block_done |=> mode_reg == kw1281_pkg::MODE_IDLE)
    `KW1281_ASSERT(a_err_to_idle,
        step && (res.error_code != kw1281_pkg::ERR_NONE)
        && (res.error_code != kw1281_pkg::ERR_SEQUENCE)
        |=> mode_reg == kw1281_pkg::MODE_IDLE)
    `KW1281_ASSERT(a_clear_count,
        step && (item.func == kw1281_pkg::FUNC_CLEAR_CNT) |=> block_count_reg == 8'd0)

endmodule

// ===== hw/rtl/kw1281_block_transfer.sv =====
// KW1281 block transfer engine top level: handshakes, config register, pipeline registers.
//
// Usage: every input transaction carries one byte event (start receive, received byte,
// tick, byte to send, clear counter) on func/data/expected_size/size_limit/last_byte,
// qualified by in_valid/in_ready. Every input transaction yields exactly one result
// transaction on tx_valid/tx_data/rx_valid/rx_index/block_done/error_code/counter_value,
// qualified by out_valid/out_ready, in the same order.
// Path: an accepted transaction goes to the input register, its result to the result
// register. Throughput: one transaction per cycle while out_ready is high; the protocol
// state update is one pass of combinational logic between the two registers.
// Stall: while out_ready is low the result is held, one more transaction is taken into
// the input register, and then in_ready drops until the result is consumed.
// Reset (rst_n low, asynchronous): both registers empty, the engine idle, the block
// counter zero and timeout_ticks back to 1100.
// Config: the APB port holds timeout_ticks at byte address 0; write it only while idle.
module kw1281_block_transfer #(
    parameter int MAX_BLOCK = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  data,
    input  logic [6:0]  expected_size,
    input  logic [6:0]  size_limit,
    input  logic        last_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_data,
    output logic        rx_valid,
    output logic [5:0]  rx_index,
    output logic        block_done,
    output logic [2:0]  error_code,
    output logic [7:0]  counter_value,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                in_valid_reg, in_valid_next;
    kw1281_pkg::item_t   in_item_reg;
    logic                out_valid_reg, out_valid_next;
    kw1281_pkg::result_t out_res_reg;
    kw1281_pkg::result_t step_res;
    logic [15:0]         timeout_reg, timeout_next;
    logic                advance;
    logic                cfg_write;
    logic                cfg_hit;

    // Move the held transaction into the result register whenever that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on acceptance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.func          <= func;
            in_item_reg.data          <= data;
            in_item_reg.expected_size <= expected_size;
            in_item_reg.size_limit    <= size_limit;
            in_item_reg.last_byte     <= last_byte;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    kw1281_engine #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (in_item_reg),
        .timeout_ticks (timeout_reg),
        .res           (step_res)
    );

    // Config register: register index is paddr[2], byte offset ignored
    assign pready    = 1'b1;
    assign cfg_hit   = paddr[2] == kw1281_pkg::REG_TIMEOUT;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_write && cfg_hit)
            timeout_next = pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= kw1281_pkg::TIMEOUT_RESET;
        else
            timeout_reg <= timeout_next;
    end

    assign prdata = cfg_hit ? {16'd0, timeout_reg} : 32'd0;

    // Result ports
    assign out_valid     = out_valid_reg;
    assign tx_valid      = out_res_reg.tx_valid;
    assign tx_data       = out_res_reg.tx_data;
    assign rx_valid      = out_res_reg.rx_valid;
    assign rx_index      = out_res_reg.rx_index;
    assign block_done    = out_res_reg.block_done;
    assign error_code    = out_res_reg.error_code;
    assign counter_value = out_res_reg.counter_value;

`include "kw1281_block_transfer_assert.svh"

    `KW1281_ASSERT(a_held_item_stays, in_valid_reg && !advance |=> in_valid_reg)
    `KW1281_ASSERT_NEVER(a_ok_with_error, out_valid && (rx_valid || block_done) && (error_code != kw1281_pkg::ERR_NONE))
    `KW1281_ASSERT_NEVER(a_tx_data_idle, out_valid && !tx_valid && (tx_data != 8'd0))
    `KW1281_ASSERT(a_advance_fills_out, advance |=> out_valid_reg)

endmodule
